[src/mbrot_pkg.sv]
// Shared types, constants and helper functions for the Mandelbrot escape-time block.
// Has no dependencies; every other file in src refers to it by scoped names.
package mbrot_pkg;

    localparam int LANE_COUNT     = 8;
    localparam int MAX_ITERATIONS = 256;
    localparam int ROW_LIMIT      = 1024;
    localparam int GROUP_LIMIT    = 128;

    localparam int OUT_LANES  = 8;
    localparam int ROW_IN_W   = 10;
    localparam int GRP_IN_W   = 7;
    localparam int OUT_CNT_W  = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_PAD_W  = OUT_DATA_W - ROW_IN_W - GRP_IN_W - OUT_LANES * OUT_CNT_W;

    localparam int ROW_W   = $clog2(ROW_LIMIT + 1);
    localparam int GRP_W   = $clog2(GROUP_LIMIT + 1);
    localparam int COL_W   = GRP_W + 3;
    localparam int COUNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam int BOUND_W = 31 + 24;

    localparam logic [OUT_CNT_W-1:0] COUNT_SAT = 8'hFF;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 3'd4;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic cmul;
        logic cinit;
        logic mul;
        logic upd;
    } t_lane_ctrl;

    typedef logic [LANE_COUNT-1:0][COUNT_W-1:0] t_count_arr;
    typedef logic [OUT_LANES-1:0][OUT_CNT_W-1:0] t_out_arr;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[src/mbrot_lane.sv]
// One escape-time lane: its c real part, its z state and its iteration count.
// Depends on mbrot_pkg; sequenced by the control struct from the top level.
module mbrot_lane (
    input  logic                              i_clk,
    input  mbrot_pkg::t_lane_ctrl             i_ctrl,
    input  logic [mbrot_pkg::COL_W-1:0]       i_column,
    input  logic signed [31:0]                i_x_min,
    input  logic signed [31:0]                i_x_step,
    input  logic signed [31:0]                i_cy,
    input  logic [mbrot_pkg::BOUND_W-1:0]     i_bound,
    output logic                              o_live,
    output logic [mbrot_pkg::COUNT_W-1:0]     o_count
);

    logic signed [mbrot_pkg::COL_W+32:0] r_cprod;
    logic signed [31:0]                  r_cx;
    logic signed [31:0]                  r_zx;
    logic signed [31:0]                  r_zy;
    logic signed [63:0]                  r_aa;
    logic signed [63:0]                  r_bb;
    logic signed [63:0]                  r_ab;
    logic [mbrot_pkg::COUNT_W-1:0]       r_count;
    logic [63:0]                         mag;

    assign mag     = $unsigned(r_aa) + $unsigned(r_bb);
    assign o_live  = mag <= 64'(i_bound);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmul) begin
            r_cprod <= $signed({1'b0, i_column}) * i_x_step;
        end
        if (i_ctrl.cinit) begin
            r_cx    <= mbrot_pkg::sat32(64'(r_cprod) + 64'(i_x_min));
            r_zx    <= '0;
            r_zy    <= '0;
            r_count <= '0;
        end
        if (i_ctrl.mul) begin
            r_aa <= r_zx * r_zx;
            r_bb <= r_zy * r_zy;
            r_ab <= r_zx * r_zy;
        end
        if (i_ctrl.upd && o_live) begin
            r_zx    <= mbrot_pkg::sat32(((r_aa - r_bb) >>> 24) + 64'(r_cx));
            r_zy    <= mbrot_pkg::sat32((r_ab >>> 23) + 64'(i_cy));
            r_count <= r_count + mbrot_pkg::COUNT_W'(1);
        end
    end

endmodule

[src/mbrot_merge.sv]
// Merges the lane results: any-lane-live flag and the saturated 8-bit counts.
// Depends on mbrot_pkg.
module mbrot_merge (
    input  logic [mbrot_pkg::LANE_COUNT-1:0] i_live,
    input  mbrot_pkg::t_count_arr            i_count,
    output logic                             o_any,
    output mbrot_pkg::t_out_arr              o_counts
);

    assign o_any = |i_live;

    always_comb begin
        o_counts = '0;
        for (int l = 0; l < mbrot_pkg::LANE_COUNT; l++) begin
            if (i_count[l] >= mbrot_pkg::COUNT_W'(mbrot_pkg::MAX_ITERATIONS)) begin
                o_counts[l] = mbrot_pkg::COUNT_SAT;
            end else begin
                o_counts[l] = mbrot_pkg::OUT_CNT_W'(i_count[l]);
            end
        end
    end

endmodule

[src/mandelbrot_escape_time_lanes.sv]
// Top level of the Mandelbrot escape-time block: registers, sequencer, lanes, output register.
// Depends on mbrot_pkg, mbrot_lane and mbrot_merge.
//
//   Channel   Direction  Signals                         Beat contents
//   s_axis    in         tvalid tready tdata[23:0]       row, column_group
//   m_axis    out        tvalid tready tdata[87:0]       out_row, out_column_group, count_0..7
//   cfg       in         i_cfg_valid o_cfg_ready         i_cfg_index, i_cfg_data
//
// A beat passes from acceptance to its result register in order: the CMUL and CINIT states
// set up c, each iteration passes through the lane multipliers (MUL) and then the compare
// and update (UPD), a last pass finds no lane live unless all 256 iterations run, and the
// DONE state loads the result.
// Reset is synchronous, active low, and restores the default view. The next beat is accepted
// while a result waits on m_axis; the sequencer only stalls at the end of an item if the
// output register is still full.
module mandelbrot_escape_time_lanes (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Bits from lowest: row[9:0], column_group[16:10], zero fill.
    input  logic [mbrot_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Bits from lowest: out_row[9:0], out_column_group[16:10], count_0 to count_7
    // at eight bits each [80:17], zero fill.
    output logic [mbrot_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CINIT,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    t_state                                  r_state;
    logic signed [31:0]                      r_x_min;
    logic signed [31:0]                      r_x_step;
    logic signed [31:0]                      r_y_min;
    logic signed [31:0]                      r_y_step;
    logic [30:0]                             r_escape_limit;
    logic [mbrot_pkg::ROW_IN_W-1:0]          r_row;
    logic [mbrot_pkg::GRP_IN_W-1:0]          r_grp;
    logic [mbrot_pkg::ROW_W-1:0]             r_rowc;
    logic [mbrot_pkg::GRP_W-1:0]             r_grpc;
    logic signed [mbrot_pkg::ROW_W+32:0]     r_yprod;
    logic signed [31:0]                      r_cy;
    logic [mbrot_pkg::COUNT_W-1:0]           r_iter;
    logic                                    r_out_valid;
    logic [mbrot_pkg::OUT_DATA_W-1:0]        r_out_data;

    mbrot_pkg::t_lane_ctrl                   lane_ctrl;
    logic [mbrot_pkg::LANE_COUNT-1:0]        lane_live;
    mbrot_pkg::t_count_arr                   lane_count;
    mbrot_pkg::t_out_arr                     out_counts;
    logic                                    any_live;
    logic [mbrot_pkg::BOUND_W-1:0]           bound;
    logic [mbrot_pkg::ROW_IN_W-1:0]          row_in;
    logic [mbrot_pkg::GRP_IN_W-1:0]          grp_in;
    logic                                    in_fire;
    logic                                    out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign row_in        = s_axis_tdata[mbrot_pkg::ROW_IN_W-1:0];
    assign grp_in        = s_axis_tdata[mbrot_pkg::ROW_IN_W +: mbrot_pkg::GRP_IN_W];
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign bound         = {r_escape_limit, 24'd0};
    assign out_load      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign lane_ctrl.cmul  = (r_state == ST_CMUL);
    assign lane_ctrl.cinit = (r_state == ST_CINIT);
    assign lane_ctrl.mul   = (r_state == ST_MUL);
    assign lane_ctrl.upd   = (r_state == ST_UPD);

    for (genvar g = 0; g < mbrot_pkg::LANE_COUNT; g++) begin : g_lane
        mbrot_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_column ({r_grpc, 3'(g)}),
            .i_x_min  (r_x_min),
            .i_x_step (r_x_step),
            .i_cy     (r_cy),
            .i_bound  (bound),
            .o_live   (lane_live[g]),
            .o_count  (lane_count[g])
        );
    end

    mbrot_merge u_merge (
        .i_live   (lane_live),
        .i_count  (lane_count),
        .o_any    (any_live),
        .o_counts (out_counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_x_min        <= -32'sd58720256;
            r_x_step       <= 32'sd125829;
            r_y_min        <= -32'sd37748736;
            r_y_step       <= 32'sd125829;
            r_escape_limit <= 31'd1677721600;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mbrot_pkg::CFG_X_MIN:        r_x_min        <= i_cfg_data;
                    mbrot_pkg::CFG_X_STEP:       r_x_step       <= i_cfg_data;
                    mbrot_pkg::CFG_Y_MIN:        r_y_min        <= i_cfg_data;
                    mbrot_pkg::CFG_Y_STEP:       r_y_step       <= i_cfg_data;
                    mbrot_pkg::CFG_ESCAPE_LIMIT: r_escape_limit <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_row <= row_in;
                        r_grp <= grp_in;
                        if (32'(row_in) >= mbrot_pkg::ROW_LIMIT) begin
                            r_rowc <= mbrot_pkg::ROW_W'(mbrot_pkg::ROW_LIMIT - 1);
                        end else begin
                            r_rowc <= mbrot_pkg::ROW_W'(row_in);
                        end
                        if (32'(grp_in) >= mbrot_pkg::GROUP_LIMIT) begin
                            r_grpc <= mbrot_pkg::GRP_W'(mbrot_pkg::GROUP_LIMIT - 1);
                        end else begin
                            r_grpc <= mbrot_pkg::GRP_W'(grp_in);
                        end
                        r_state <= ST_CMUL;
                    end
                end
                ST_CMUL: begin
                    r_yprod <= $signed({1'b0, r_rowc}) * r_y_step;
                    r_state <= ST_CINIT;
                end
                ST_CINIT: begin
                    r_cy    <= mbrot_pkg::sat32(64'(r_yprod) + 64'(r_y_min));
                    r_iter  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (!any_live ||
                        r_iter == mbrot_pkg::COUNT_W'(mbrot_pkg::MAX_ITERATIONS - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_iter  <= r_iter + mbrot_pkg::COUNT_W'(1);
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_data  <= {{mbrot_pkg::OUT_PAD_W{1'b0}}, out_counts, r_grp, r_row};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
